// ----- rtl/huffman_tree_walk_decoder_unit_defines.svh -----
// Assertion macros shared by the Huffman tree-walk decoder.
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HTWD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/htwd_pkg.sv -----
// Shared types and constants of the Huffman tree-walk decoder.
package htwd_pkg;

    localparam int NODE_W  = 9;
    localparam int SYM_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 4;
    localparam int KIDS_W  = 2 * NODE_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int BITS_PER_ITEM    = 8;

    // Bits taken from one item at most.
    localparam logic [CNT_W-1:0] BIT_LIMIT =
        CNT_W'((BITS_PER_ITEM < DATA_W) ? BITS_PER_ITEM : DATA_W);

    localparam logic [NODE_W-1:0] ROOT_RESET = NODE_W'(510);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam logic REG_ROOT = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_emit;

    typedef struct packed {
        logic              idle;
        logic              pend;
        logic [NODE_W-1:0] walk;
    } t_walk_stat;

endpackage

// ----- rtl/htwd_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module htwd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 255,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/htwd_cfg.sv -----
// Configuration register file: holds the root node number.
module htwd_cfg
    import htwd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [NODE_W-1:0]  o_root
);

    logic [NODE_W-1:0] r_root;
    logic              w_idx;

    assign w_idx  = paddr[PADDR_W-1];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= ROOT_RESET;
        end else if (psel && penable && pwrite && w_idx == REG_ROOT) begin
            r_root <= pwdata[NODE_W-1:0];
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROOT: prdata = {{(PDATA_W-NODE_W){1'b0}}, r_root};
            default:  prdata = '0;
        endcase
    end

    assign o_root = r_root;

endmodule

// ----- rtl/htwd_walker.sv -----
// Tree-walk sequencer: child-table memory and one bit step per cycle unless a finished symbol waits for output room.
module htwd_walker
    import htwd_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [SLOT_W-1:0] i_node_slot,
    input  logic [NODE_W-1:0] i_left_child,
    input  logic [NODE_W-1:0] i_right_child,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic [CNT_W-1:0]  i_bit_count,
    input  logic [NODE_W-1:0] i_root,
    input  logic              i_out_free,
    output t_emit             o_emit,
    output t_walk_stat        o_stat
);

    localparam int EXT_W = 13;
    localparam logic [EXT_W-1:0] SC_W      = EXT_W'(SYMBOL_COUNT);
    localparam logic [EXT_W-1:0] TBL_DEPTH = EXT_W'(SYMBOL_COUNT - 1);
    localparam int MEM_DEPTH = (SYMBOL_COUNT - 1 < 256) ? SYMBOL_COUNT - 1 : 256;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_walk, n_walk;
    logic [DATA_W-1:0] r_data, n_data;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_pend, n_pend;
    logic [SYM_W-1:0]  r_pend_sym, n_pend_sym;

    logic              w_we;
    logic [AW-1:0]     w_raddr;
    logic [KIDS_W-1:0] w_rdata;
    logic [KIDS_W-1:0] w_kids;
    logic [EXT_W-1:0]  w_cur_ext, w_cur_slot, w_nxt_slot;
    logic              w_internal, w_in_tbl, w_nxt_leaf;
    logic [NODE_W-1:0] w_nxt;
    logic [CNT_W-1:0]  w_count;

    htwd_ram #(
        .WIDTH (KIDS_W),
        .DEPTH (MEM_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_node_slot[AW-1:0]),
        .i_wdata ({i_right_child, i_left_child}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The read data always belongs to r_walk: each cycle reads the slot of the next position.
    always_comb begin
        w_cur_ext  = {{(EXT_W-NODE_W){1'b0}}, r_walk};
        w_internal = w_cur_ext >= SC_W;
        w_cur_slot = w_cur_ext - SC_W;
        w_in_tbl   = w_internal && (w_cur_slot < TBL_DEPTH);
        w_kids     = w_in_tbl ? w_rdata : '0;
        if (w_internal) begin
            w_nxt = r_data[0] ? w_kids[KIDS_W-1:NODE_W] : w_kids[NODE_W-1:0];
        end else begin
            w_nxt = r_walk;
        end
        w_nxt_leaf = {{(EXT_W-NODE_W){1'b0}}, w_nxt} < SC_W;
        w_count    = (i_bit_count > BIT_LIMIT) ? BIT_LIMIT : i_bit_count;

        n_state    = r_state;
        n_walk     = r_walk;
        n_data     = r_data;
        n_left     = r_left;
        n_pend     = r_pend;
        n_pend_sym = r_pend_sym;
        w_we       = 1'b0;
        o_emit     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_LOAD) begin
                        n_walk = i_root;
                        w_we   = {{(EXT_W-SLOT_W){1'b0}}, i_node_slot} < TBL_DEPTH;
                    end else if (w_count != '0) begin
                        n_data  = i_data_byte;
                        n_left  = w_count;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // A leaf with a symbol already held waits for room at the output.
                if (!w_nxt_leaf || !r_pend || i_out_free) begin
                    n_data = r_data >> 1;
                    n_left = r_left - CNT_W'(1);
                    if (w_nxt_leaf) begin
                        n_walk        = i_root;
                        o_emit.valid  = r_pend;
                        o_emit.symbol = r_pend_sym;
                        o_emit.last   = 1'b0;
                        n_pend        = 1'b1;
                        n_pend_sym    = w_nxt[SYM_W-1:0];
                    end else begin
                        n_walk = w_nxt;
                    end
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.symbol = r_pend_sym;
                    o_emit.last   = 1'b1;
                    n_pend        = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        w_nxt_slot = {{(EXT_W-NODE_W){1'b0}}, n_walk} - SC_W;
        w_raddr    = w_nxt_slot[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= ROOT_RESET;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_left  <= n_left;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_pend_sym <= n_pend_sym;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.pend = r_pend;
    assign o_stat.walk = r_walk;

endmodule

// ----- rtl/huffman_tree_walk_decoder_unit.sv -----
// Top level of the Huffman tree-walk decoder: register port, walker and output stage.
//
// A load item writes one internal node's children into the child table and
// sends the walk back to the root. A decode item is accepted in idle, then
// takes one bit step per valid bit (bit_count, capped at eight) and closes the
// item in a flush state; a step or the flush may wait while the output is
// stalled. A decode item with a bit count of zero is accepted and starts no walk.
// Each bit step depends on the previous child-table read, so the
// registered read loop through the child memory sets the rate. Symbols
// leave through an output register, so a finished symbol may wait while the
// walk goes on; the last symbol of an item is held back until the item's
// bits are spent so that it can carry the last flag. The child table has no
// reset: a walk through a node that was never loaded gives undefined symbols.
`include "huffman_tree_walk_decoder_unit_defines.svh"

module huffman_tree_walk_decoder_unit
    import htwd_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [SLOT_W-1:0]  i_node_slot,
    input  logic [NODE_W-1:0]  i_left_child,
    input  logic [NODE_W-1:0]  i_right_child,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic [CNT_W-1:0]   i_bit_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last
);

    logic [NODE_W-1:0] w_root;
    t_emit             w_emit;
    t_walk_stat        w_stat;
    logic              w_out_free;
    logic              r_out_valid;
    logic [SYM_W-1:0]  r_symbol;
    logic              r_last;

    htwd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_root  (w_root)
    );

    htwd_walker #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_node_slot   (i_node_slot),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_data_byte   (i_data_byte),
        .i_bit_count   (i_bit_count),
        .i_root        (w_root),
        .i_out_free    (w_out_free),
        .o_emit        (w_emit),
        .o_stat        (w_stat)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_symbol <= w_emit.symbol;
            r_last   <= w_emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;

    `HTWD_ASSERT(a_emit_room, w_emit.valid, !r_out_valid || i_out_ready, "symbol pushed over a waiting item")
    `HTWD_ASSERT(a_idle_clear, w_stat.idle, !w_stat.pend, "held symbol left behind at item end")
    `HTWD_ASSERT_NEXT(a_load_root, i_in_valid && o_in_ready && i_action == ACT_LOAD, w_stat.walk == $past(w_root), "load did not return the walk to the root")
    `HTWD_ASSERT_NEXT(a_last_ends, w_emit.valid && w_emit.last, w_stat.idle, "walker busy after the last symbol")

endmodule
